// File: rtl/core/bdll_pkg.sv
// ----------------------------------------------------------------------------
// Bounded doubly linked list package
// Sizes, request and status codes, and element conversion helpers shared by
// the list core.
// ----------------------------------------------------------------------------
package bdll_pkg;

  // Store geometry.
  localparam int CAPACITY      = 64;
  localparam int ELEMENT_WIDTH = 32;
  localparam int SLOT_W        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W         = $clog2(CAPACITY + 1);

  // Fixed field widths of the request and result items.
  localparam int REQ_W     = 2;
  localparam int VALUE_W   = 32;
  localparam int POS_W     = 6;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 7;
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 40;

  // Comparison width wide enough for both a position and a count.
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic [SLOT_W-1:0]        slot_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [ELEMENT_WIDTH-1:0] elem_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND  = 2'd0,
    REQ_READ    = 2'd1,
    REQ_REMOVE  = 2'd2,
    REQ_REVERSE = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_PAST  = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // Keep the low element bits of a sign-extended input value.
  function automatic elem_t elem_from_in(input logic signed [VALUE_W-1:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    return w[ELEMENT_WIDTH-1:0];
  endfunction

  // Sign-extend a stored element and keep the low bits of the data field.
  function automatic logic [VALUE_W-1:0] elem_to_out(input elem_t v);
    logic signed [ELEMENT_WIDTH-1:0] sv;
    logic signed [63:0]              w;
    sv = v;
    w  = 64'(sv);
    return w[VALUE_W-1:0];
  endfunction

endpackage

// File: rtl/core/bounded_doubly_linked_list_core.sv
// ----------------------------------------------------------------------------
// Bounded doubly linked list core
// An ordered store of up to CAPACITY signed elements held as a doubly linked
// list in slot memories, with a free slot stack. Each request appends, reads
// at a position, removes at a position or reverses the order, and gives one
// result carrying status, data and the element count. One request is in work
// at a time. A read or remove walks the list, following one link per cycle
// through the registered read port of the link memories. A finished result
// waits in the output register while the next request is accepted. No
// clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module bounded_doubly_linked_list_core (
  input  logic                          clk,
  input  logic                          rst,
  // Request channel.
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // s_tdata, lowest bit up: value[31:0], position[37:32], zero fill.
  input  logic [bdll_pkg::S_TDATA_W-1:0] s_tdata,
  // s_tuser: req_type[1:0].
  input  logic [bdll_pkg::REQ_W-1:0]     s_tuser,
  // Result channel.
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // m_tdata, lowest bit up: data[31:0], count[38:32], zero fill.
  output logic [bdll_pkg::M_TDATA_W-1:0] m_tdata,
  // m_tuser: status[1:0].
  output logic [bdll_pkg::STATUS_W-1:0]  m_tuser
);

  import bdll_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_APPEND,
    S_WALK,
    S_DONE
  } state_t;

  state_t state;

  // Request being served.
  req_t                       req_kind;
  logic signed [VALUE_W-1:0]  req_val;
  logic [POS_W-1:0]           req_pos;

  // List control state.
  cnt_t  cnt;
  slot_t first_slot;
  slot_t last_slot;
  logic  rev;

  // Walk state.
  slot_t            cur;
  logic [POS_W-1:0] idx;

  // Result held until the output register is free.
  status_t            res_status;
  logic [VALUE_W-1:0] res_data;

  // Slot memories and the free slot stack.
  elem_t val_mem [CAPACITY];
  slot_t fwd_mem [CAPACITY];
  slot_t bwd_mem [CAPACITY];
  slot_t stk_mem [CAPACITY];
  logic [CAPACITY-1:0] stk_vld;

  // Registered read data.
  elem_t val_q;
  slot_t fwd_q;
  slot_t bwd_q;
  slot_t free_q;

  // Write ports.
  logic  val_we, fwd_we, bwd_we, stk_we;
  slot_t val_wa, fwd_wa, bwd_wa, stk_wa;
  elem_t val_wd;
  slot_t fwd_wd, bwd_wd, stk_wd;

  slot_t rd_addr;
  slot_t next_q;
  slot_t prev_q;
  slot_t stk_top;
  logic  at_pos;
  logic  out_free;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // Link directions follow the reversal flag.
  assign next_q = rev ? bwd_q : fwd_q;
  assign prev_q = rev ? fwd_q : bwd_q;

  // The walk reads the next slot; otherwise the front is kept ready.
  assign rd_addr = (state == S_WALK) ? next_q : first_slot;

  // Stack index of the next free slot: CAPACITY - 1 - count.
  assign stk_top = SLOT_W'(CAPACITY - 1) - cnt[SLOT_W-1:0];

  assign at_pos = (idx == req_pos);

  // Memory write requests for append and remove.
  always_comb begin
    val_we = 1'b0;
    fwd_we = 1'b0;
    bwd_we = 1'b0;
    stk_we = 1'b0;
    val_wa = free_q;
    val_wd = elem_from_in(req_val);
    fwd_wa = last_slot;
    fwd_wd = free_q;
    bwd_wa = free_q;
    bwd_wd = last_slot;
    stk_wa = stk_top + slot_t'(1);
    stk_wd = cur;
    case (state)
      S_APPEND: begin
        val_we = 1'b1;
        if (cnt != '0) begin
          fwd_we = 1'b1;
          bwd_we = 1'b1;
          if (rev) begin
            bwd_wa = last_slot;
            bwd_wd = free_q;
            fwd_wa = free_q;
            fwd_wd = last_slot;
          end
        end
      end
      S_WALK: begin
        if (at_pos && req_kind == REQ_REMOVE) begin
          stk_we = 1'b1;
          if (cnt != cnt_t'(1)) begin
            // Link the predecessor forward to the successor.
            if (cur != first_slot) begin
              if (rev) begin
                bwd_we = 1'b1;
                bwd_wa = prev_q;
                bwd_wd = next_q;
              end else begin
                fwd_we = 1'b1;
                fwd_wa = prev_q;
                fwd_wd = next_q;
              end
            end
            // Link the successor back to the predecessor.
            if (cur != last_slot) begin
              if (rev) begin
                fwd_we = 1'b1;
                fwd_wa = next_q;
                fwd_wd = prev_q;
              end else begin
                bwd_we = 1'b1;
                bwd_wa = next_q;
                bwd_wd = prev_q;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Slot memories with registered reads.
  always_ff @(posedge clk) begin
    if (val_we) val_mem[val_wa] <= val_wd;
    if (fwd_we) fwd_mem[fwd_wa] <= fwd_wd;
    if (bwd_we) bwd_mem[bwd_wa] <= bwd_wd;
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    val_q <= val_mem[rd_addr];
    fwd_q <= fwd_mem[rd_addr];
    bwd_q <= bwd_mem[rd_addr];
    // An untouched stack entry still holds its reset slot index.
    if (stk_vld[stk_top]) free_q <= stk_mem[stk_top];
    else                  free_q <= SLOT_W'(CAPACITY - 1) - stk_top;
  end

  // Valid bits of the free slot stack.
  always_ff @(posedge clk) begin
    if (rst) begin
      stk_vld <= '0;
    end else if (stk_we) begin
      stk_vld[stk_wa] <= 1'b1;
    end
  end

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      first_slot <= '0;
      last_slot  <= '0;
      rev        <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      // A taken result frees the output register unless a new one is loaded.
      if (m_tvalid && m_tready && state != S_DONE) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            req_kind   <= req_t'(s_tuser);
            req_val    <= s_tdata[VALUE_W-1:0];
            req_pos    <= s_tdata[VALUE_W +: POS_W];
            res_data   <= '0;
            res_status <= ST_OK;
            cur        <= first_slot;
            idx        <= '0;
            case (req_t'(s_tuser))
              REQ_APPEND: begin
                if (cnt == cnt_t'(CAPACITY)) begin
                  res_status <= ST_FULL;
                  state      <= S_DONE;
                end else begin
                  state <= S_APPEND;
                end
              end
              REQ_READ, REQ_REMOVE: begin
                if (cnt == '0) begin
                  res_status <= ST_EMPTY;
                  state      <= S_DONE;
                end else if (CMP_W'(s_tdata[VALUE_W +: POS_W]) >= CMP_W'(cnt)) begin
                  res_status <= ST_PAST;
                  state      <= S_DONE;
                end else begin
                  state <= S_WALK;
                end
              end
              default: begin
                // Reverse: swap the ends and the link roles.
                first_slot <= last_slot;
                last_slot  <= first_slot;
                rev        <= ~rev;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_APPEND: begin
          if (cnt == '0) first_slot <= free_q;
          last_slot <= free_q;
          cnt       <= cnt + cnt_t'(1);
          state     <= S_DONE;
        end
        S_WALK: begin
          if (at_pos) begin
            res_data <= elem_to_out(val_q);
            if (req_kind == REQ_REMOVE) begin
              if (cnt == cnt_t'(1)) begin
                first_slot <= '0;
                last_slot  <= '0;
              end else begin
                if (cur == first_slot) first_slot <= next_q;
                if (cur == last_slot)  last_slot  <= prev_q;
              end
              cnt <= cnt - cnt_t'(1);
            end
            state <= S_DONE;
          end else begin
            cur <= next_q;
            idx <= idx + POS_W'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{(M_TDATA_W - VALUE_W - COUNT_W){1'b0}}, COUNT_W'(cnt), res_data};
            m_tuser  <= res_status;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // An accepted request holds off new requests in the cycle after acceptance.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while the previous one was starting");

  // Handing over a result always raises the output valid.
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> (m_tvalid && state == S_IDLE))
    else $error("result not presented after completion");

  // The count moves by at most one per cycle and never passes capacity.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    ##1 (cnt == $past(cnt) || cnt == $past(cnt) + cnt_t'(1) || cnt == $past(cnt) - cnt_t'(1))
        && cnt <= cnt_t'(CAPACITY))
    else $error("element count changed by more than one");

  // The walk never runs beyond the requested position.
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (idx <= req_pos && CMP_W'(req_pos) < CMP_W'(cnt)))
    else $error("list walk ran past the requested position");

endmodule
